FILE: design/terrain_vertex_lod_cull_test_macros.svh
// assertion macros used by the checker file of the terrain vertex test
// no dependencies
`ifndef TERRAIN_VERTEX_LOD_CULL_TEST_MACROS_SVH
`define TERRAIN_VERTEX_LOD_CULL_TEST_MACROS_SVH

// property checked on the rising clock, switched off while reset is low
`define TVLC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tvlc assertion failed");

// property checked on every rising clock, reset included
`define TVLC_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("tvlc assertion failed");

`endif

FILE: design/tvlc_pkg.sv
// types and constants of the terrain vertex lod and cull test
// used by tvlc_div and terrain_vertex_lod_cull_test
`default_nettype none
package tvlc_pkg;
    localparam int COORD_W    = 21;
    localparam int RAD_W      = 20;
    localparam int MASK_W     = 4;
    localparam int NUM_PLANES = 4;
    localparam int NRM_W      = 12;
    localparam int OFF_W      = 24;
    localparam int PROD_W     = NRM_W + COORD_W;
    localparam int DIST_W     = PROD_W + 7;
    localparam int LIM_W      = RAD_W + 4;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int D2_W       = SQ_W + 2;
    localparam int LOD_W      = 16;
    localparam int LERR_W     = LOD_W + RAD_W;
    localparam int A_W        = LERR_W - 8 + 1;
    localparam int A2_W       = 2 * A_W;
    localparam int DIV_W      = 44;
    localparam int T_W        = 17;
    localparam int MUL_W      = T_W + 1 + DIFF_W;
    localparam int IN_W       = 4 * COORD_W + 2 * RAD_W + MASK_W;
    localparam int OUT_W      = 32;
    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    typedef enum logic [2:0] {
        REG_PLANE_BOTTOM,
        REG_PLANE_LEFT,
        REG_PLANE_RIGHT,
        REG_PLANE_TOP,
        REG_EYE_POSITION,
        REG_LOD_SCALE,
        REG_CULL_MARGIN,
        REG_CLIP_ENABLE
    } cfg_reg_t;

    // per-vertex control and payload that rides along the divider
    typedef struct packed {
        logic                      active;
        logic                      morph;
        logic signed [COORD_W-1:0] zm;
        logic signed [DIFF_W-1:0]  dzm;
        logic [MASK_W-1:0]         mask;
    } side_t;
endpackage
`default_nettype wire

FILE: design/tvlc_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on tvlc_pkg
`default_nettype none
module tvlc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [tvlc_pkg::DIV_W-1:0] in_num,
    input  logic [tvlc_pkg::DIV_W-1:0] in_den,
    input  tvlc_pkg::side_t            in_side,
    output logic                       out_valid,
    output logic [tvlc_pkg::T_W-1:0]   out_q,
    output tvlc_pkg::side_t            out_side
);
    import tvlc_pkg::*;

    logic             vld_reg  [T_W];
    logic [DIV_W-1:0] rem_reg  [T_W];
    logic [DIV_W-1:0] den_reg  [T_W];
    logic [T_W-1:0]   q_reg    [T_W];
    side_t            side_reg [T_W];

    genvar s;
    generate
        for (s = 0; s < T_W; s++) begin : g_step
            logic             p_vld;
            logic [DIV_W-1:0] p_rem;
            logic [DIV_W-1:0] p_den;
            logic [T_W-1:0]   p_q;
            side_t            p_side;
            logic [DIV_W:0]   rem2;
            logic             ge;
            logic [DIV_W-1:0] rem_next;
            logic [T_W-1:0]   q_next;

            if (s == 0) begin : g_first
                assign p_vld  = in_valid;
                assign p_rem  = in_num;
                assign p_den  = in_den;
                assign p_q    = '0;
                assign p_side = in_side;
            end else begin : g_rest
                assign p_vld  = vld_reg[s-1];
                assign p_rem  = rem_reg[s-1];
                assign p_den  = den_reg[s-1];
                assign p_q    = q_reg[s-1];
                assign p_side = side_reg[s-1];
            end

            // shift remainder, subtract divisor when it fits
            assign rem2     = {p_rem, 1'b0};
            assign ge       = rem2 >= {1'b0, p_den};
            assign rem_next = ge ? DIV_W'(rem2 - {1'b0, p_den}) : rem2[DIV_W-1:0];
            assign q_next   = {p_q[T_W-2:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[s] <= 1'b0;
                end else if (en) begin
                    vld_reg[s] <= p_vld;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s]  <= rem_next;
                    den_reg[s]  <= p_den;
                    q_reg[s]    <= q_next;
                    side_reg[s] <= p_side;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[T_W-1];
    assign out_q     = q_reg[T_W-1];
    assign out_side  = side_reg[T_W-1];
endmodule
`default_nettype wire

FILE: design/terrain_vertex_lod_cull_test.sv
// Terrain vertex lod and frustum cull test. Takes one vertex per clock while
// s_tready is high and returns one result per vertex, passing through four
// arithmetic stages, a 17-stage divider that forms the morph factor one
// quotient bit per stage, a multiply stage and the output register. A
// one-entry skid buffer after the pipeline fills when the output stalls with
// the output register full; s_tready stays low while it is full.
// Configuration writes are taken in every cycle (cfg_ready is tied high).
`default_nettype none
module terrain_vertex_lod_cull_test #(
    parameter int PLANE_COUNT = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // vertex_x, vertex_y, vertex_z, morph_z, bound_radius, error_bound, mask_in
    input  logic [tvlc_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // plot_height, mask_out, zero fill
    output logic [tvlc_pkg::OUT_W-1:0] m_tdata,
    // is_active
    output logic [0:0]                 m_tuser,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [63:0]                cfg_data
);
    import tvlc_pkg::*;

    localparam int NP = (PLANE_COUNT < NUM_PLANES) ? PLANE_COUNT : NUM_PLANES;

    // configuration registers
    logic [63:0]      plane_reg [NUM_PLANES];
    logic [62:0]      eye_reg;
    logic [LOD_W-1:0] lod_reg;
    logic [RAD_W-1:0] margin_reg;
    logic             clip_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) plane_reg[i] <= '0;
            eye_reg    <= '0;
            lod_reg    <= LOD_W'(256);
            margin_reg <= '0;
            clip_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PLANE_BOTTOM, REG_PLANE_LEFT,
                REG_PLANE_RIGHT, REG_PLANE_TOP: plane_reg[cfg_index[1:0]] <= cfg_data;
                REG_EYE_POSITION: eye_reg    <= cfg_data[62:0];
                REG_LOD_SCALE:    lod_reg    <= cfg_data[LOD_W-1:0];
                REG_CULL_MARGIN:  margin_reg <= cfg_data[RAD_W-1:0];
                REG_CLIP_ENABLE:  clip_reg   <= cfg_data[0];
            endcase
        end
    end

    // pipeline advances while the skid buffer is empty
    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // input unpack
    logic signed [COORD_W-1:0] in_x, in_y, in_z, in_zm;
    logic [RAD_W-1:0]          in_r, in_err;
    logic [MASK_W-1:0]         in_mask;
    assign in_x    = s_tdata[COORD_W-1:0];
    assign in_y    = s_tdata[2*COORD_W-1:COORD_W];
    assign in_z    = s_tdata[3*COORD_W-1:2*COORD_W];
    assign in_zm   = s_tdata[4*COORD_W-1:3*COORD_W];
    assign in_r    = s_tdata[4*COORD_W+RAD_W-1:4*COORD_W];
    assign in_err  = s_tdata[4*COORD_W+2*RAD_W-1:4*COORD_W+RAD_W];
    assign in_mask = s_tdata[IN_W-1:IN_W-MASK_W];

    logic signed [COORD_W-1:0] eye_x, eye_y, eye_z;
    assign eye_x = eye_reg[COORD_W-1:0];
    assign eye_y = eye_reg[2*COORD_W-1:COORD_W];
    assign eye_z = eye_reg[3*COORD_W-1:2*COORD_W];

    // stage 1: plane products, eye differences, lod times error
    logic                      v1_reg;
    logic signed [PROD_W-1:0]  px_reg [NUM_PLANES];
    logic signed [PROD_W-1:0]  py_reg [NUM_PLANES];
    logic signed [PROD_W-1:0]  pz_reg [NUM_PLANES];
    logic signed [OFF_W-1:0]   off_reg [NUM_PLANES];
    logic signed [DIFF_W-1:0]  dx1_reg, dy1_reg, dz1_reg, dzm1_reg;
    logic [LERR_W-1:0]         lerr1_reg;
    logic [RAD_W-1:0]          r1_reg;
    logic [MASK_W-1:0]         mask1_reg;
    logic signed [COORD_W-1:0] zm1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                px_reg[i]  <= PROD_W'($signed(plane_reg[i][NRM_W-1:0])) * PROD_W'(in_x);
                py_reg[i]  <= PROD_W'($signed(plane_reg[i][2*NRM_W-1:NRM_W])) * PROD_W'(in_y);
                pz_reg[i]  <= PROD_W'($signed(plane_reg[i][3*NRM_W-1:2*NRM_W]))
                              * PROD_W'(in_z);
                off_reg[i] <= plane_reg[i][3*NRM_W+OFF_W-1:3*NRM_W];
            end
            dx1_reg   <= DIFF_W'(eye_x) - DIFF_W'(in_x);
            dy1_reg   <= DIFF_W'(eye_y) - DIFF_W'(in_y);
            dz1_reg   <= DIFF_W'(eye_z) - DIFF_W'(in_z);
            dzm1_reg  <= DIFF_W'(in_z) - DIFF_W'(in_zm);
            lerr1_reg <= LERR_W'(lod_reg) * LERR_W'(in_err);
            r1_reg    <= in_r;
            mask1_reg <= in_mask;
            zm1_reg   <= in_zm;
        end
    end

    // stage 2: plane distances, cull limit, squared eye distances, lod radius
    logic [DIFF_W-1:0] mx, my, mz, mzm;
    assign mx  = dx1_reg[DIFF_W-1]  ? DIFF_W'(-dx1_reg)  : DIFF_W'(dx1_reg);
    assign my  = dy1_reg[DIFF_W-1]  ? DIFF_W'(-dy1_reg)  : DIFF_W'(dy1_reg);
    assign mz  = dz1_reg[DIFF_W-1]  ? DIFF_W'(-dz1_reg)  : DIFF_W'(dz1_reg);
    assign mzm = dzm1_reg[DIFF_W-1] ? DIFF_W'(-dzm1_reg) : DIFF_W'(dzm1_reg);

    logic                      v2_reg;
    logic signed [DIST_W-1:0]  dist2_reg [NUM_PLANES];
    logic [LIM_W-1:0]          lim2_reg;
    logic [SQ_W-1:0]           bx2_reg, by2_reg, bz2_reg;
    logic [A_W-1:0]            a2v_reg;
    logic [RAD_W-1:0]          r2_reg;
    logic [MASK_W-1:0]         mask2_reg;
    logic signed [COORD_W-1:0] zm2_reg;
    logic signed [DIFF_W-1:0]  dzm2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                dist2_reg[i] <= DIST_W'(px_reg[i]) + DIST_W'(py_reg[i]) + DIST_W'(pz_reg[i])
                                + (DIST_W'(off_reg[i]) <<< 11);
            end
            lim2_reg  <= LIM_W'(margin_reg) + LIM_W'(mzm) + LIM_W'(r1_reg);
            bx2_reg   <= SQ_W'(mx) * SQ_W'(mx);
            by2_reg   <= SQ_W'(my) * SQ_W'(my);
            bz2_reg   <= SQ_W'(mz) * SQ_W'(mz);
            a2v_reg   <= A_W'(lerr1_reg[LERR_W-1:8]) + A_W'(r1_reg);
            r2_reg    <= r1_reg;
            mask2_reg <= mask1_reg;
            zm2_reg   <= zm1_reg;
            dzm2_reg  <= dzm1_reg;
        end
    end

    // stage 3: plane decisions, a squared, eye distance squared
    logic signed [DIST_W-1:0] cull_lim, in_lim;
    logic                     culled_next;
    logic [MASK_W-1:0]        mask_next;
    assign cull_lim = -(DIST_W'(lim2_reg) <<< 11);
    assign in_lim   = DIST_W'(r2_reg) <<< 11;

    always_comb begin
        culled_next = 1'b0;
        mask_next   = mask2_reg;
        if (clip_reg) begin
            for (int i = 0; i < NP; i++) begin
                if (!mask2_reg[i]) begin
                    if (dist2_reg[i] < cull_lim) culled_next = 1'b1;
                    if (dist2_reg[i] > in_lim)   mask_next[i] = 1'b1;
                end
            end
        end
    end

    logic                      v3_reg;
    logic                      culled3_reg;
    logic [MASK_W-1:0]         mask3_reg, maskin3_reg;
    logic [A2_W-1:0]           asq3_reg;
    logic [D2_W-1:0]           d2_3_reg;
    logic signed [COORD_W-1:0] zm3_reg;
    logic signed [DIFF_W-1:0]  dzm3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            culled3_reg <= culled_next;
            mask3_reg   <= mask_next;
            maskin3_reg <= mask2_reg;
            asq3_reg    <= A2_W'(a2v_reg) * A2_W'(a2v_reg);
            d2_3_reg    <= D2_W'(bx2_reg) + D2_W'(by2_reg) + D2_W'(bz2_reg);
            zm3_reg     <= zm2_reg;
            dzm3_reg    <= dzm2_reg;
        end
    end

    // stage 4: classify metric, normalize divider operands
    logic              d2_zero, below, above, act4, morph4;
    logic [D2_W-1:0]   num_full;
    logic [DIV_W-1:0]  num_next, den_next;
    side_t             side_next;

    assign d2_zero  = d2_3_reg == '0;
    assign below    = asq3_reg < A2_W'(d2_3_reg);
    assign above    = {asq3_reg, 1'b0} > (A2_W+1)'(3 * (A2_W+1)'(d2_3_reg));
    assign act4     = !culled3_reg && (d2_zero || !below);
    assign morph4   = act4 && !d2_zero && !above;
    assign num_full = D2_W'(asq3_reg - A2_W'(d2_3_reg));

    always_comb begin
        if (d2_3_reg[D2_W-1]) begin
            num_next = DIV_W'(num_full >> 2);
            den_next = DIV_W'(d2_3_reg >> 2);
        end else if (d2_3_reg[D2_W-2]) begin
            num_next = DIV_W'(num_full >> 1);
            den_next = DIV_W'(d2_3_reg >> 1);
        end else begin
            num_next = DIV_W'(num_full);
            den_next = DIV_W'(d2_3_reg);
        end
        side_next.active = act4;
        side_next.morph  = morph4;
        side_next.zm     = zm3_reg;
        side_next.dzm    = dzm3_reg;
        side_next.mask   = act4 ? mask3_reg : maskin3_reg;
    end

    logic             v4_reg;
    logic [DIV_W-1:0] num4_reg, den4_reg;
    side_t            side4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num4_reg  <= num_next;
            den4_reg  <= den_next;
            side4_reg <= side_next;
        end
    end

    // morph factor division
    logic           dv_valid;
    logic [T_W-1:0] dv_q;
    side_t          dv_side;

    tvlc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (den4_reg),
        .in_side   (side4_reg),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    // multiply stage: clamp factor, full height plots with factor one
    logic [T_W-1:0]         t_sel;
    logic signed [T_W:0]    t_s;
    assign t_sel = (dv_side.morph && (dv_q <= T_ONE)) ? dv_q : T_ONE;
    assign t_s   = {1'b0, t_sel};

    logic                    v5_reg;
    logic signed [MUL_W-1:0] prod5_reg;
    side_t                   side5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en)  v5_reg <= dv_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod5_reg <= MUL_W'(t_s) * MUL_W'(dv_side.dzm);
            side5_reg <= dv_side;
        end
    end

    // rounding and final height
    logic signed [MUL_W-1:0]   rnd;
    logic signed [COORD_W-1:0] plot;
    logic [OUT_W-1:0]          res_data;
    assign rnd      = prod5_reg + MUL_W'(32768);
    assign plot     = side5_reg.active
                    ? COORD_W'(side5_reg.zm + COORD_W'(rnd >>> 16)) : '0;
    assign res_data = OUT_W'({side5_reg.mask, plot});

    // output register with skid buffer
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg, skid_data_reg;
    logic             out_user_reg, skid_user_reg;
    logic             take, push;
    assign take = out_valid_reg && m_tready;
    assign push = en && v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || take) out_valid_reg <= 1'b1;
            else                        skid_valid_reg <= 1'b1;
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || take) begin
                out_data_reg <= res_data;
                out_user_reg <= side5_reg.active;
            end else begin
                skid_data_reg <= res_data;
                skid_user_reg <= side5_reg.active;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
endmodule
`default_nettype wire

FILE: design/tvlc_checker.sv
// port-level checks of the terrain vertex test, bound to the top level
// depends on terrain_vertex_lod_cull_test_macros.svh
`default_nettype none
`include "terrain_vertex_lod_cull_test_macros.svh"
module tvlc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);
    // no result leaves right after reset
    `TVLC_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid)
    // a stalled result holds
    `TVLC_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // inactive vertex plots zero height
    `TVLC_ASSERT(a_inactive_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata[20:0] == 0)
    // fill bits stay zero
    `TVLC_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[31:25] == 0)
endmodule

bind terrain_vertex_lod_cull_test tvlc_checker u_tvlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
